// File: rtl/assert_macros.svh
// assertion macros shared by the vector to longitude/latitude rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define VLL_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while in reset
`define VLL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/vll_pkg.sv
// shared constants and arctangent table for the vector to longitude/latitude block
`default_nettype none
package vll_pkg;

    localparam int COORD_WIDTH_DEF  = 32;
    localparam int ANGLE_WIDTH_DEF  = 32;
    localparam int CORDIC_STEPS_DEF = 32;

    // angle accumulator width, units of 2^-32 turn
    localparam int ACC_W = 36;

    localparam logic signed [ACC_W-1:0] HALF_TURN    = 36'sd2147483648;
    localparam logic signed [ACC_W-1:0] QUARTER_TURN = 36'sd1073741824;
    localparam logic [31:0]             INV_GAIN     = 32'd2608131496;

    // round(atan(2^-i) / (2 pi) * 2^32)
    function automatic logic [31:0] atan_step(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/vector_to_lon_lat.sv
// top level: longitude and latitude of a 3-d vector via two pipelined cordic passes
// Takes one (x, y, z) vector per cycle and returns longitude in [0, 1 turn) and latitude
// clamped to plus or minus a quarter turn, both in units of 2^-ANGLE_WIDTH turn. The pipeline
// is one input stage, CORDIC_STEPS stages for the longitude pass, two stages for the gain
// multiply and rounding, CORDIC_STEPS stages for the latitude pass and one output stage.
// The whole pipeline advances together, so throughput is one beat per cycle whenever the
// output side is ready; a stalled output freezes every stage.
`default_nettype none
`include "assert_macros.svh"
module vector_to_lon_lat
    import vll_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // x_coord, y_coord, z_coord, zero pad
    input  wire logic [((3*COORD_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // longitude, latitude, zero pad
    output logic [((2*ANGLE_WIDTH+7)/8)*8-1:0]       m_axis_tdata
);

    localparam int XW      = COORD_WIDTH + 4;
    localparam int OUT_W   = ((2*ANGLE_WIDTH+7)/8)*8;
    localparam int TAG1_W  = COORD_WIDTH + 2;
    localparam int TAG2_W  = 33;

    logic en;

    logic signed [COORD_WIDTH-1:0] x_in;
    logic signed [COORD_WIDTH-1:0] y_in;
    logic signed [COORD_WIDTH-1:0] z_in;
    logic signed [XW-1:0]          x_ext;
    logic signed [XW-1:0]          y_ext;

    logic                          in_valid_reg;
    logic signed [XW-1:0]          x0_reg;
    logic signed [XW-1:0]          y0_reg;
    logic signed [ACC_W-1:0]       a0_reg;
    logic [TAG1_W-1:0]             tag0_reg;

    logic                          c1_valid;
    logic signed [XW-1:0]          c1_x;
    logic signed [ACC_W-1:0]       c1_a;
    logic [TAG1_W-1:0]             c1_tag;
    logic                          c1_xy_zero;
    logic                          c1_z_zero;
    logic signed [COORD_WIDTH-1:0] c1_z;
    logic [XW-1:0]                 len;
    logic [31:0]                   lon32;
    logic [COORD_WIDTH+32:0]       g_tag_in;

    logic                          g_valid;
    logic [XW-1:0]                 g_r;
    logic [COORD_WIDTH+32:0]       g_tag;
    logic signed [COORD_WIDTH-1:0] g_z;

    logic                          c2_valid;
    logic signed [XW-1:0]          c2_x;
    logic signed [ACC_W-1:0]       c2_a;
    logic [TAG2_W-1:0]             c2_tag;
    logic signed [ACC_W-1:0]       lat_clamp;
    logic [31:0]                   lat32;
    logic [ANGLE_WIDTH+31:0]       lon_scaled;
    logic [ANGLE_WIDTH+31:0]       lat_scaled;

    logic                          out_valid_reg;
    logic [ANGLE_WIDTH-1:0]        lon_reg;
    logic [ANGLE_WIDTH-1:0]        lat_reg;

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;

    assign x_in  = s_axis_tdata[COORD_WIDTH-1:0];
    assign y_in  = s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign z_in  = s_axis_tdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
    assign x_ext = XW'(x_in);
    assign y_ext = XW'(y_in);

    // input stage: fold the left half-plane onto the right
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (x_in[COORD_WIDTH-1])
            begin
                x0_reg <= -x_ext;
                y0_reg <= -y_ext;
                a0_reg <= HALF_TURN;
            end
            else
            begin
                x0_reg <= x_ext;
                y0_reg <= y_ext;
                a0_reg <= '0;
            end
            tag0_reg <= {z_in == '0, (x_in == '0) && (y_in == '0), z_in};
        end
    end

    vll_cordic #(
        .XW    (XW),
        .STEPS (CORDIC_STEPS),
        .TW    (TAG1_W)
    ) u_lon_pass (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid_reg),
        .in_x      (x0_reg),
        .in_y      (y0_reg),
        .in_a      (a0_reg),
        .in_tag    (tag0_reg),
        .out_valid (c1_valid),
        .out_x     (c1_x),
        .out_a     (c1_a),
        .out_tag   (c1_tag)
    );

    assign c1_z       = c1_tag[COORD_WIDTH-1:0];
    assign c1_xy_zero = c1_tag[COORD_WIDTH];
    assign c1_z_zero  = c1_tag[COORD_WIDTH+1];
    assign len        = (c1_xy_zero || c1_x[XW-1]) ? '0 : c1_x;
    assign lon32      = c1_xy_zero ? 32'd0 : c1_a[31:0];
    assign g_tag_in   = {c1_z_zero, lon32, c1_z};

    vll_gain #(
        .XW (XW),
        .TW (COORD_WIDTH + 33)
    ) u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c1_valid),
        .in_len    (len),
        .in_tag    (g_tag_in),
        .out_valid (g_valid),
        .out_r     (g_r),
        .out_tag   (g_tag)
    );

    assign g_z = g_tag[COORD_WIDTH-1:0];

    vll_cordic #(
        .XW    (XW),
        .STEPS (CORDIC_STEPS),
        .TW    (TAG2_W)
    ) u_lat_pass (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (g_valid),
        .in_x      (g_r),
        .in_y      (XW'(g_z)),
        .in_a      ('0),
        .in_tag    (g_tag[COORD_WIDTH+32:COORD_WIDTH]),
        .out_valid (c2_valid),
        .out_x     (c2_x),
        .out_a     (c2_a),
        .out_tag   (c2_tag)
    );

    always_comb
    begin
        if (c2_tag[32])
        begin
            lat_clamp = '0;
        end
        else if (c2_a > QUARTER_TURN)
        begin
            lat_clamp = QUARTER_TURN;
        end
        else if (c2_a < -QUARTER_TURN)
        begin
            lat_clamp = -QUARTER_TURN;
        end
        else
        begin
            lat_clamp = c2_a;
        end
    end

    // rescale from 2^-32 turn to 2^-ANGLE_WIDTH turn
    assign lat32      = lat_clamp[31:0];
    assign lon_scaled = {c2_tag[31:0], {ANGLE_WIDTH{1'b0}}};
    assign lat_scaled = {lat32, {ANGLE_WIDTH{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= c2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lon_reg <= lon_scaled[ANGLE_WIDTH+31:32];
            lat_reg <= lat_scaled[ANGLE_WIDTH+31:32];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({lat_reg, lon_reg});

    `VLL_ASSERT_IMPL(a_lat_clamped, clk, rst_n, c2_valid,
        (lat_clamp <= QUARTER_TURN) && (lat_clamp >= -QUARTER_TURN))
    `VLL_ASSERT_NEXT(a_lat_zero_z, clk, rst_n, en && c2_valid && c2_tag[32],
        lat_reg == '0)

    logic unused_x;
    assign unused_x = ^c2_x;

endmodule
`default_nettype wire

// File: rtl/vll_cordic.sv
// pipelined cordic vectoring pass, one register stage per iteration
`default_nettype none
`include "assert_macros.svh"
module vll_cordic
    import vll_pkg::*;
#(
    parameter int XW    = 36,
    parameter int STEPS = 32,
    parameter int TW    = 1
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire logic                    in_valid,
    input  wire logic signed [XW-1:0]    in_x,
    input  wire logic signed [XW-1:0]    in_y,
    input  wire logic signed [ACC_W-1:0] in_a,
    input  wire logic [TW-1:0]           in_tag,
    output logic                         out_valid,
    output logic signed [XW-1:0]         out_x,
    output logic signed [ACC_W-1:0]      out_a,
    output logic [TW-1:0]                out_tag
);

    logic                    valid_reg [1:STEPS];
    logic signed [XW-1:0]    x_reg     [1:STEPS];
    logic signed [XW-1:0]    y_reg     [1:STEPS];
    logic signed [ACC_W-1:0] a_reg     [1:STEPS];
    logic [TW-1:0]           tag_reg   [1:STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        localparam logic signed [ACC_W-1:0] STEP = {{(ACC_W-32){1'b0}}, atan_step(k)};
        logic                    vs;
        logic signed [XW-1:0]    xs;
        logic signed [XW-1:0]    ys;
        logic signed [ACC_W-1:0] as;
        logic [TW-1:0]           ts;
        logic signed [XW-1:0]    dx;
        logic signed [XW-1:0]    dy;

        if (k == 0) begin : g_src_in
            assign vs = in_valid;
            assign xs = in_x;
            assign ys = in_y;
            assign as = in_a;
            assign ts = in_tag;
        end
        else begin : g_src_reg
            assign vs = valid_reg[k];
            assign xs = x_reg[k];
            assign ys = y_reg[k];
            assign as = a_reg[k];
            assign ts = tag_reg[k];
        end

        assign dx = ys >>> k;
        assign dy = xs >>> k;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= vs;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tag_reg[k+1] <= ts;
                if (!ys[XW-1])
                begin
                    x_reg[k+1] <= xs + dx;
                    y_reg[k+1] <= ys - dy;
                    a_reg[k+1] <= as + STEP;
                end
                else
                begin
                    x_reg[k+1] <= xs - dx;
                    y_reg[k+1] <= ys + dy;
                    a_reg[k+1] <= as - STEP;
                end
            end
        end
    end

    assign out_valid = valid_reg[STEPS];
    assign out_x     = x_reg[STEPS];
    assign out_a     = a_reg[STEPS];
    assign out_tag   = tag_reg[STEPS];

    `VLL_ASSERT_NEXT(a_first_stage_load, clk, rst_n, en, valid_reg[1] == $past(in_valid))
    `VLL_ASSERT_NEXT(a_last_stage_hold, clk, rst_n, !en,
        valid_reg[STEPS] == $past(valid_reg[STEPS]))

endmodule
`default_nettype wire

// File: rtl/vll_gain.sv
// inverse cordic gain correction, multiply then round, two stages
`default_nettype none
module vll_gain
    import vll_pkg::*;
#(
    parameter int XW = 36,
    parameter int TW = 1
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [XW-1:0] in_len,
    input  wire logic [TW-1:0] in_tag,
    output logic               out_valid,
    output logic [XW-1:0]      out_r,
    output logic [TW-1:0]      out_tag
);

    logic             prod_valid_reg;
    logic [XW+31:0]   prod_reg;
    logic [TW-1:0]    prod_tag_reg;
    logic             r_valid_reg;
    logic [XW-1:0]    r_reg;
    logic [TW-1:0]    r_tag_reg;
    logic [XW+31:0]   rounded;

    assign rounded = prod_reg + {{XW{1'b0}}, 32'h8000_0000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            r_valid_reg    <= 1'b0;
        end
        else if (en)
        begin
            prod_valid_reg <= in_valid;
            r_valid_reg    <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg     <= {32'd0, in_len} * {{XW{1'b0}}, INV_GAIN};
            prod_tag_reg <= in_tag;
            r_reg        <= rounded[XW+31:32];
            r_tag_reg    <= prod_tag_reg;
        end
    end

    assign out_valid = r_valid_reg;
    assign out_r     = r_reg;
    assign out_tag   = r_tag_reg;

endmodule
`default_nettype wire
